### src/acl_pkg.sv
// Shared types, constants and helpers for the IPv4 first-match access list.
// No dependencies; imported by every module in src.
package acl_pkg;

  localparam int MAX_RULES = 64;
  localparam int ADDR_BITS = 32;
  localparam int LEN_W     = 6;
  localparam int IDX_W     = $clog2(MAX_RULES);
  localparam int CNT_W     = $clog2(MAX_RULES + 1);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ADDR_BITS);
  localparam logic [CNT_W-1:0] NO_RULE = CNT_W'(MAX_RULES);

  localparam logic [1:0] MODE_ALLOW = 2'd0;
  localparam int         MODE_QUERY_BIT = 1;

  localparam logic [1:0] STAT_STORED = 2'd0;
  localparam logic [1:0] STAT_ALLOW  = 2'd1;
  localparam logic [1:0] STAT_DENY   = 2'd2;
  localparam logic [1:0] STAT_FULL   = 2'd3;

  typedef struct packed {
    logic [ADDR_BITS-1:0] prefix;
    logic [LEN_W-1:0]     len;
    logic                 allows;
  } rule_t;

  function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_BITS-1:0] m;
    m = '1;
    if (len == '0) begin
      m = '0;
    end else if (len < LEN_MAX) begin
      m = m << (LEN_MAX - len);
    end
    return m;
  endfunction

endpackage

### src/acl_rule_mem.sv
// Rule storage: one write port, one read port, registered read data.
// Depends on acl_pkg for the rule record and index width.
module acl_rule_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [acl_pkg::IDX_W-1:0]  waddr,
  input  acl_pkg::rule_t             wdata,
  input  logic [acl_pkg::IDX_W-1:0]  raddr,
  output acl_pkg::rule_t             rdata
);
  import acl_pkg::*;

  rule_t mem [MAX_RULES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/acl_match.sv
// Prefix compare of one stored rule against a lookup address.
// Depends on acl_pkg for the rule record and prefix_mask.
module acl_match (
  input  logic [acl_pkg::ADDR_BITS-1:0] address,
  input  acl_pkg::rule_t                rule,
  output logic                          hit
);
  import acl_pkg::*;

  logic [ADDR_BITS-1:0] mask;

  assign mask = prefix_mask(rule.len);
  assign hit  = ((address ^ rule.prefix) & mask) == '0;

endmodule

### src/cidr_acl_first_match_filter.sv
// IPv4 access list with first-match lookup: top level, control and output register.
// Depends on acl_pkg, acl_rule_mem and acl_match.
//
// Each request either appends an allow/deny rule (address plus prefix length, saturated
// to 32) or looks up an address. An append is answered straight from the idle state. A
// lookup examines the stored rules in order up to the first match (all stored rules
// when none matches, at most MAX_RULES); the single read port of the rule memory sets
// this, one rule per cycle. A lookup on an empty list is answered without a scan. When the
// output register is still held by a stalled response, the finished result waits in a
// hold state until the register frees. The block takes a new request whenever it is
// idle, even while a response waits to be transferred.
module cidr_acl_first_match_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    mode,
  input  logic [acl_pkg::ADDR_BITS-1:0] address,
  input  logic [acl_pkg::LEN_W-1:0]     prefix_len,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [1:0]                    status,
  output logic [acl_pkg::CNT_W-1:0]     matched_rule
);
  import acl_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_HOLD} state_t;

  state_t               state;
  logic [CNT_W-1:0]     rule_count;
  logic [IDX_W-1:0]     idx;
  logic [ADDR_BITS-1:0] q_addr;
  logic [1:0]           pend_status;
  logic [CNT_W-1:0]     pend_which;

  logic                 accept;
  logic                 is_query;
  logic                 full;
  logic                 out_free;
  logic                 load;
  logic                 last;
  logic                 hit;
  logic                 fin;
  logic [1:0]           fin_status;
  logic [CNT_W-1:0]     fin_which;
  logic [LEN_W-1:0]     len_sat;
  logic                 we;
  rule_t                wdata;
  rule_t                rdata;
  logic [IDX_W-1:0]     raddr;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign is_query  = mode[MODE_QUERY_BIT];
  assign full      = (rule_count == NO_RULE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign load      = out_free && (fin || state == ST_HOLD);
  assign last      = ((CNT_W'(idx) + CNT_W'(1)) == rule_count);
  assign len_sat   = (prefix_len > LEN_MAX) ? LEN_MAX : prefix_len;

  assign we            = accept && !is_query && !full;
  assign wdata.prefix  = address & prefix_mask(len_sat);
  assign wdata.len     = len_sat;
  assign wdata.allows  = (mode == MODE_ALLOW);
  assign raddr         = (state == ST_SCAN) ? idx + IDX_W'(1) : '0;

  acl_rule_mem u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (rule_count[IDX_W-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  acl_match u_match (
    .address (q_addr),
    .rule    (rdata),
    .hit     (hit)
  );

  always_comb begin
    fin        = 1'b0;
    fin_status = STAT_ALLOW;
    fin_which  = NO_RULE;
    if (state == ST_IDLE && accept) begin
      if (!is_query) begin
        fin = 1'b1;
        if (full) begin
          fin_status = STAT_FULL;
        end else begin
          fin_status = STAT_STORED;
          fin_which  = rule_count;
        end
      end else if (rule_count == '0) begin
        fin = 1'b1;
      end
    end else if (state == ST_SCAN) begin
      if (hit) begin
        fin        = 1'b1;
        fin_status = rdata.allows ? STAT_ALLOW : STAT_DENY;
        fin_which  = CNT_W'(idx);
      end else if (last) begin
        fin = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rsp_valid  <= 1'b0;
      rule_count <= '0;
    end else begin
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!is_query) begin
              if (!full) begin
                rule_count <= rule_count + CNT_W'(1);
              end
            end else begin
              q_addr <= address;
              idx    <= '0;
              if (rule_count != '0) begin
                state <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (!fin) begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            status       <= pend_status;
            matched_rule <= pend_which;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (fin) begin
        if (out_free) begin
          status       <= fin_status;
          matched_rule <= fin_which;
          state        <= ST_IDLE;
        end else begin
          pend_status <= fin_status;
          pend_which  <= fin_which;
          state       <= ST_HOLD;
        end
      end
    end
  end

endmodule
